[rtl/core/lia_pkg.sv]
package lia_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_ORIGIN_Z = 2'd2;

  localparam logic [14:0] COS_CLAMP = 15'd32764;
  localparam logic [13:0] ANGLE_MAX = 14'd11520;

  localparam int CORDIC_STEPS = 18;

  // atan(2^-i) in 1/65536 degree, rounded to nearest.
  localparam logic [21:0] ATAN_TAB [CORDIC_STEPS] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29
  };

  // One classified point as it travels from the front part to the back part.
  typedef struct packed {
    logic [49:0] sum_sq;  // squared range in mm^2
    logic [40:0] mag;     // |n . d| in Q1.15 mm
    logic        inv;     // point coincides with the origin
  } q_entry_t;

endpackage

[rtl/core/lia_front.sv]
module lia_front
  import lia_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8,
  parameter int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] point_x,
  input  logic signed [23:0] point_y,
  input  logic signed [23:0] point_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic [CW-1:0]      q_count,
  output logic               push,
  output q_entry_t           push_entry
);

  logic signed [23:0] origin_x, origin_y, origin_z;

  logic               f1_valid, f2_valid, f3_valid;
  logic signed [24:0] dx, dy, dz;
  logic signed [15:0] nx, ny, nz;
  logic signed [49:0] sqx, sqy, sqz;
  logic signed [40:0] prx, pry, prz;
  logic [49:0]        sum_sq;
  logic signed [42:0] dot;
  logic [CW:0]        occupancy;
  logic               accept;
  q_entry_t           f3_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      origin_z <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        REG_ORIGIN_Z: origin_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Every point already in the front part is counted as queue space taken.
  assign occupancy = {1'b0, q_count} + (CW+1)'(f1_valid) + (CW+1)'(f2_valid)
                   + (CW+1)'(f3_valid);
  assign in_stall  = occupancy >= (CW+1)'(QUEUE_DEPTH);
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    dx  <= 25'(point_x) - 25'(origin_x);
    dy  <= 25'(point_y) - 25'(origin_y);
    dz  <= 25'(point_z) - 25'(origin_z);
    nx  <= normal_x;
    ny  <= normal_y;
    nz  <= normal_z;
    sqx <= dx * dx;
    sqy <= dy * dy;
    sqz <= dz * dz;
    prx <= nx * dx;
    pry <= ny * dy;
    prz <= nz * dz;
    f3_entry <= '{sum_sq: sum_sq,
                  mag:    dot[42] ? 41'(-dot) : 41'(dot),
                  inv:    sum_sq == '0};
  end

  assign sum_sq = $unsigned(sqx) + $unsigned(sqy) + $unsigned(sqz);
  assign dot    = 43'(prx) + 43'(pry) + 43'(prz);

  assign push       = f3_valid;
  assign push_entry = f3_entry;

endmodule

[rtl/core/lia_queue.sv]
module lia_queue
  import lia_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8,
  parameter int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  q_entry_t      push_entry,
  input  logic          pop,
  output logic          head_valid,
  output q_entry_t      head_entry,
  output logic [CW-1:0] count
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  q_entry_t      slots [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign head_valid = count != '0;
  assign head_entry = slots[rd_ptr];

endmodule

[rtl/core/lia_back.sv]
module lia_back
  import lia_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  q_entry_t    head_entry,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [24:0] range_mm,
  output logic [14:0] cos_incidence,
  output logic [13:0] angle_deg,
  output logic        invalid
);

  localparam int S1 = 25;            // range square root, one bit a stage
  localparam int DV = 15;            // cosine division, one quotient bit a stage
  localparam int S2 = 16;            // sine square root
  localparam int CR = CORDIC_STEPS;
  localparam int NV = S1 + 3 + DV + 3 + S2 + CR;

  typedef struct packed {
    logic [49:0] op;
    logic [24:0] root;
    logic [26:0] rem;
    logic [40:0] mag;
    logic        inv;
  } sq1_t;

  typedef struct packed {
    logic [41:0] rem;
    logic [14:0] q;
    logic [24:0] r;
    logic        clamp;
    logic        inv;
  } div_t;

  typedef struct packed {
    logic [31:0] op;
    logic [15:0] root;
    logic [17:0] rem;
    logic [14:0] c;
    logic [24:0] r;
    logic        inv;
  } sq2_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [25:0] z;
    logic [14:0]        c;
    logic [24:0]        r;
    logic               inv;
  } cor_t;

  logic          en;
  logic [NV-1:0] vld;

  sq1_t a [1:S1];
  div_t d [1:DV];
  sq2_t b [1:S2];
  cor_t k [1:CR];

  // Range rounding and division setup.
  logic [24:0] rd1_r, rd2_r;
  logic [40:0] rd1_mag;
  logic        rd1_inv, rd2_inv;
  logic [41:0] rd2_num;
  logic [39:0] rd2_lim;
  div_t        rd3;

  // Cosine, its square and the sine argument.
  logic [14:0] cs1_c, cs2_c, cs3_c;
  logic [24:0] cs1_r, cs2_r, cs3_r;
  logic        cs1_inv, cs2_inv, cs3_inv;
  logic [29:0] cs2_csq;
  logic [31:0] cs3_v;

  logic signed [25:0] z_fin, z_round;

  // The whole back part moves in lock step; only a held result stops it.
  assign en  = !(out_valid && out_stall);
  assign pop = en && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NV-2:0], head_valid};
    end
  end

  for (genvar i = 0; i < S1; i++) begin : g_sq1
    sq1_t        cur;
    logic [28:0] rn, t;
    if (i == 0) begin : g_in
      assign cur = '{op: head_entry.sum_sq, root: '0, rem: '0,
                     mag: head_entry.mag, inv: head_entry.inv};
    end else begin : g_rg
      assign cur = a[i];
    end
    assign rn = {cur.rem, cur.op[49:48]};
    assign t  = {2'b00, cur.root, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        a[i+1].op  <= {cur.op[47:0], 2'b00};
        a[i+1].mag <= cur.mag;
        a[i+1].inv <= cur.inv;
        if (rn >= t) begin
          a[i+1].rem  <= 27'(rn - t);
          a[i+1].root <= {cur.root[23:0], 1'b1};
        end else begin
          a[i+1].rem  <= rn[26:0];
          a[i+1].root <= {cur.root[23:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Round the root to nearest: bump it when the remainder exceeds the root.
      rd1_r   <= a[S1].root + 25'({2'b00, a[S1].root} < a[S1].rem);
      rd1_mag <= a[S1].mag;
      rd1_inv <= a[S1].inv;
      rd2_num <= {1'b0, rd1_mag} + {18'd0, rd1_r[24:1]};
      rd2_lim <= rd1_r * 15'(COS_CLAMP + 15'd1);
      rd2_r   <= rd1_r;
      rd2_inv <= rd1_inv;
      rd3.rem   <= rd2_num;
      rd3.q     <= '0;
      rd3.r     <= rd2_r;
      rd3.clamp <= rd2_num >= {2'b00, rd2_lim};
      rd3.inv   <= rd2_inv;
    end
  end

  for (genvar i = 0; i < DV; i++) begin : g_div
    div_t        cur;
    logic [41:0] dsr;
    if (i == 0) begin : g_in
      assign cur = rd3;
    end else begin : g_rg
      assign cur = d[i];
    end
    assign dsr = 42'(cur.r) << (DV - 1 - i);
    always_ff @(posedge clk) begin
      if (en) begin
        d[i+1].r     <= cur.r;
        d[i+1].clamp <= cur.clamp;
        d[i+1].inv   <= cur.inv;
        if (cur.rem >= dsr) begin
          d[i+1].rem <= cur.rem - dsr;
          d[i+1].q   <= cur.q | (15'd1 << (DV - 1 - i));
        end else begin
          d[i+1].rem <= cur.rem;
          d[i+1].q   <= cur.q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs1_c   <= d[DV].clamp ? COS_CLAMP : d[DV].q;
      cs1_r   <= d[DV].r;
      cs1_inv <= d[DV].inv;
      cs2_csq <= cs1_c * cs1_c;
      cs2_c   <= cs1_c;
      cs2_r   <= cs1_r;
      cs2_inv <= cs1_inv;
      cs3_v   <= 32'h4000_0000 - {2'b00, cs2_csq};
      cs3_c   <= cs2_c;
      cs3_r   <= cs2_r;
      cs3_inv <= cs2_inv;
    end
  end

  for (genvar i = 0; i < S2; i++) begin : g_sq2
    sq2_t        cur;
    logic [19:0] rn, t;
    if (i == 0) begin : g_in
      assign cur = '{op: cs3_v, root: '0, rem: '0, c: cs3_c, r: cs3_r, inv: cs3_inv};
    end else begin : g_rg
      assign cur = b[i];
    end
    assign rn = {cur.rem, cur.op[31:30]};
    assign t  = {2'b00, cur.root, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        b[i+1].op  <= {cur.op[29:0], 2'b00};
        b[i+1].c   <= cur.c;
        b[i+1].r   <= cur.r;
        b[i+1].inv <= cur.inv;
        if (rn >= t) begin
          b[i+1].rem  <= 18'(rn - t);
          b[i+1].root <= {cur.root[14:0], 1'b1};
        end else begin
          b[i+1].rem  <= rn[17:0];
          b[i+1].root <= {cur.root[14:0], 1'b0};
        end
      end
    end
  end

  for (genvar i = 0; i < CR; i++) begin : g_cor
    cor_t               cur;
    logic signed [33:0] xs, ys;
    if (i == 0) begin : g_in
      assign cur = '{x: 34'(b[S2].c) << 14, y: 34'(b[S2].root) << 14, z: '0,
                     c: b[S2].c, r: b[S2].r, inv: b[S2].inv};
    end else begin : g_rg
      assign cur = k[i];
    end
    assign xs = cur.x >>> i;
    assign ys = cur.y >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        k[i+1].c   <= cur.c;
        k[i+1].r   <= cur.r;
        k[i+1].inv <= cur.inv;
        if (!cur.y[33]) begin
          k[i+1].x <= cur.x + ys;
          k[i+1].y <= cur.y - xs;
          k[i+1].z <= cur.z + 26'(ATAN_TAB[i]);
        end else begin
          k[i+1].x <= cur.x - ys;
          k[i+1].y <= cur.y + xs;
          k[i+1].z <= cur.z - 26'(ATAN_TAB[i]);
        end
      end
    end
  end

  assign z_fin   = k[CR].z;
  assign z_round = (z_fin + 26'sd256) >>> 9;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[NV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      invalid <= k[CR].inv;
      if (k[CR].inv) begin
        range_mm      <= '0;
        cos_incidence <= '0;
        angle_deg     <= '0;
      end else begin
        range_mm      <= k[CR].r;
        cos_incidence <= k[CR].c;
        if (z_fin[25]) begin
          angle_deg <= '0;
        end else if (z_round > 26'(ANGLE_MAX)) begin
          angle_deg <= ANGLE_MAX;
        end else begin
          angle_deg <= z_round[13:0];
        end
      end
    end
  end

endmodule

[rtl/core/lidar_incidence_angle.sv]
// Lidar incidence angle. Each beat on the input channel carries one point (mm) and
// its surface normal (Q1.15); the scanner origin comes from three configuration
// registers. Each point yields one output beat: the rounded range to the origin,
// the incidence cosine |n . d| / range in Q0.15 clamped at 0.9999, and the angle
// in 1/128 degree. A point on the origin gives invalid with all other fields zero.
// One point is taken every clock while in_stall is low; each point passes through
// three front stages, the queue, the 25-stage range square root, the 15-stage
// cosine divider, the 16-stage sine square root and the 18-stage CORDIC, with
// setup stages between them. A queue of QUEUE_DEPTH points lets the front keep
// accepting while the output is stalled for a short while.
module lidar_incidence_angle
  import lia_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] point_x,
  input  logic signed [23:0] point_y,
  input  logic signed [23:0] point_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [24:0]        range_mm,
  output logic [14:0]        cos_incidence,
  output logic [13:0]        angle_deg,
  output logic               invalid
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          push, pop, head_valid;
  q_entry_t      push_entry, head_entry;
  logic [CW-1:0] q_count;

  lia_front #(.QUEUE_DEPTH(QUEUE_DEPTH), .CW(CW)) u_front (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .point_x, .point_y, .point_z,
    .normal_x, .normal_y, .normal_z,
    .q_count, .push, .push_entry
  );

  lia_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .CW(CW)) u_queue (
    .clk, .rst, .push, .push_entry, .pop, .head_valid, .head_entry,
    .count(q_count)
  );

  lia_back u_back (
    .clk, .rst, .head_valid, .head_entry, .pop,
    .out_valid, .out_stall, .range_mm, .cos_incidence, .angle_deg, .invalid
  );

endmodule

[rtl/core/lia_checker.sv]
module lia_checker
  import lia_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [24:0] range_mm,
  input logic [14:0] cos_incidence,
  input logic [13:0] angle_deg,
  input logic        invalid
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(range_mm)
      && $stable(cos_incidence) && $stable(angle_deg) && $stable(invalid))
    else $error("output beat changed while stalled");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |-> range_mm == '0 && cos_incidence == '0 && angle_deg == '0)
    else $error("invalid beat carries nonzero fields");

  a_range_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !invalid |-> range_mm != '0)
    else $error("valid point with zero range");

  a_limits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cos_incidence <= COS_CLAMP && angle_deg <= ANGLE_MAX)
    else $error("cosine or angle out of range");

endmodule

bind lidar_incidence_angle lia_checker u_lia_checker (.*);
